FILE: design/assert_macros.svh
// assertion helpers included by the generator top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/mtg_pkg.sv
`default_nettype none

package mtg_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W = 20;
  localparam int unsigned SHIFT_DIST = 397;

  // opcodes of the input item
  localparam logic [1:0] OP_SEED = 2'd0;
  localparam logic [1:0] OP_NEXT = 2'd1;
  localparam logic [1:0] OP_SKIP = 2'd2;

  localparam logic [WORD_W-1:0] INIT_MULT = 32'h6C07_8965;
  localparam logic [WORD_W-1:0] TWIST_XOR = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] UPPER_BIT = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOWER_BITS = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] TEMPER_B = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_C = 32'hEFC6_0000;

  typedef logic [WORD_W-1:0] word_t;

  // output tempering
  function automatic word_t temper(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // one twist step from the current, following and far words
  function automatic word_t twist_word(input word_t cur, input word_t nxt, input word_t far);
    word_t y;
    word_t mag;
    y = (cur & UPPER_BIT) | (nxt & LOWER_BITS);
    mag = y[0] ? TWIST_XOR : '0;
    return far ^ (y >> 1) ^ mag;
  endfunction

endpackage

`default_nettype wire

FILE: design/mtg_word_ram.sv
`default_nettype none

module mtg_word_ram #(
  parameter int unsigned DEPTH = 624,
  parameter int unsigned AW = 10
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [mtg_pkg::WORD_W-1:0] wr_data,
  input  wire logic [AW-1:0]              rd_a_addr,
  input  wire logic [AW-1:0]              rd_b_addr,
  output logic      [mtg_pkg::WORD_W-1:0] rd_a_data,
  output logic      [mtg_pkg::WORD_W-1:0] rd_b_data
);

  mtg_pkg::word_t mem [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

`default_nettype wire

FILE: design/mtg_mul_unit.sv
`default_nettype none

module mtg_mul_unit (
  input  wire logic                       clk,
  input  wire logic [mtg_pkg::WORD_W-1:0] mul_x,
  output logic      [mtg_pkg::WORD_W-1:0] prod
);

  mtg_pkg::word_t prod_r;

  // registered low word of x times the init multiplier
  always_ff @(posedge clk) begin
    prod_r <= mtg_pkg::WORD_W'(mul_x * mtg_pkg::INIT_MULT);
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

FILE: design/mt19937_generator_top.sv
// MT19937 generator, 32-bit words, one input channel and one result channel.
// Input item: in_opcode selects load seed, next word or skip; in_seed_value and
// in_skip_count are used only by the operation that needs them. An unused
// opcode, or next/skip before the first seed, is dropped without effect.
// Result item: out_random_word (tempered word) and out_lcg_word (that word
// after two steps of x*0x6C078965+1), one per next operation, none otherwise.
// in_ready is high only while the sequencer is idle; one item is worked at a
// time through a 624x32 word memory (two read ports, one write port) and one
// registered 32x32 multiplier shared by seeding and the lcg steps.
// Per item: a seed writes each word after a multiply; a next reads a word,
// tempers it, runs both lcg steps and loads the result; a twist (due every 624
// words) works each word with a read state then a write state, set by the
// read-then-write of the memory, and one more pass through the read state;
// a skip jumps the index by whole runs and runs each twist it triggers.
// A finished result sits in the output register while out_ready is low; the
// sequencer then waits before loading the next one. Reset (rst_n low,
// synchronous) clears the seeded flag and sets the read index to the end; the
// memory is not cleared, since nothing reads it before a seed fills every word.
`default_nettype none

`include "assert_macros.svh"

module mt19937_generator_top #(
  parameter int unsigned STATE_WORDS = 624
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                in_opcode,
  input  wire logic [31:0]               in_seed_value,
  input  wire logic [mtg_pkg::CNT_W-1:0] in_skip_count,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [31:0]                    out_random_word,
  output logic [31:0]                    out_lcg_word
);

  localparam int unsigned AW = $clog2(STATE_WORDS);
  localparam int unsigned IW = $clog2(STATE_WORDS + 1);
  localparam logic [IW-1:0] IDX_END = IW'(STATE_WORDS);
  localparam logic [AW-1:0] LAST_K = AW'(STATE_WORDS - 1);
  localparam logic [AW:0] FAR_OFS = (AW+1)'(mtg_pkg::SHIFT_DIST);
  localparam logic [AW:0] WRAP = (AW+1)'(STATE_WORDS);

  typedef enum logic [3:0] {
    S_IDLE, S_SD_MUL, S_SD_WR, S_TW_PRE, S_TW_CUR, S_TW_RD, S_TW_WR,
    S_NX, S_NX_DATA, S_NX_M1, S_NX_M2, S_NX_M3, S_NX_OUT, S_SK
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    seeded_r, seeded_nxt;
  logic                    for_skip_r, for_skip_nxt;
  logic [IW-1:0]           index_r, index_nxt;
  logic [AW-1:0]           k_r, k_nxt;
  logic [mtg_pkg::CNT_W-1:0] rem_r, rem_nxt;
  mtg_pkg::word_t          p_r, p_nxt;
  mtg_pkg::word_t          cur_r, cur_nxt;
  mtg_pkg::word_t          word_r, word_nxt;
  mtg_pkg::word_t          lcg_r, lcg_nxt;
  logic                    out_valid_r, out_valid_nxt;
  mtg_pkg::word_t          out_rand_r, out_rand_nxt;
  mtg_pkg::word_t          out_lcg_r, out_lcg_nxt;

  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  mtg_pkg::word_t          wr_data;
  logic [AW-1:0]           rd_a_addr;
  logic [AW-1:0]           rd_b_addr;
  mtg_pkg::word_t          rd_a_data;
  mtg_pkg::word_t          rd_b_data;
  mtg_pkg::word_t          mul_x;
  mtg_pkg::word_t          prod;

  logic                    in_acc;
  logic [AW-1:0]           nxt_addr;
  logic [AW:0]             far_sum;
  logic [AW-1:0]           far_addr;
  logic [IW-1:0]           avail;
  mtg_pkg::word_t          seed_word;

  mtg_word_ram #(
    .DEPTH (STATE_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  mtg_mul_unit u_mul (
    .clk   (clk),
    .mul_x (mul_x),
    .prod  (prod)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_random_word = out_rand_r;
  assign out_lcg_word = out_lcg_r;

  // twist neighbor addresses, wrapping at the store depth
  assign nxt_addr = (k_r == LAST_K) ? '0 : k_r + 1'b1;
  assign far_sum = {1'b0, k_r} + FAR_OFS;
  assign far_addr = (far_sum >= WRAP) ? AW'(far_sum - WRAP) : far_sum[AW-1:0];
  assign avail = IDX_END - index_r;
  assign seed_word = prod + mtg_pkg::WORD_W'(k_r);

  // sequencer next state and datapath
  always_comb begin
    state_nxt = state_r;
    seeded_nxt = seeded_r;
    for_skip_nxt = for_skip_r;
    index_nxt = index_r;
    k_nxt = k_r;
    rem_nxt = rem_r;
    p_nxt = p_r;
    cur_nxt = cur_r;
    word_nxt = word_r;
    lcg_nxt = lcg_r;
    out_valid_nxt = out_valid_r;
    out_rand_nxt = out_rand_r;
    out_lcg_nxt = out_lcg_r;
    wr_en = 1'b0;
    wr_addr = k_r;
    wr_data = seed_word;
    rd_a_addr = nxt_addr;
    rd_b_addr = far_addr;
    mul_x = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_opcode)
            mtg_pkg::OP_SEED: begin
              wr_en = 1'b1;
              wr_addr = '0;
              wr_data = in_seed_value;
              p_nxt = in_seed_value;
              k_nxt = AW'(1);
              state_nxt = S_SD_MUL;
            end
            mtg_pkg::OP_NEXT: begin
              if (seeded_r) begin
                state_nxt = S_NX;
              end
            end
            mtg_pkg::OP_SKIP: begin
              if (seeded_r) begin
                rem_nxt = in_skip_count;
                state_nxt = S_SK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // seed fill: multiply then add the word index
      S_SD_MUL: begin
        mul_x = p_r ^ (p_r >> 30);
        state_nxt = S_SD_WR;
      end
      S_SD_WR: begin
        wr_en = 1'b1;
        wr_data = seed_word;
        p_nxt = seed_word;
        if (k_r == LAST_K) begin
          index_nxt = IDX_END;
          seeded_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
          state_nxt = S_SD_MUL;
        end
      end
      // twist: prime with word zero, then read-modify-write each word
      S_TW_PRE: begin
        rd_a_addr = '0;
        state_nxt = S_TW_CUR;
      end
      S_TW_CUR: begin
        cur_nxt = rd_a_data;
        k_nxt = '0;
        state_nxt = S_TW_RD;
      end
      S_TW_RD: begin
        state_nxt = S_TW_WR;
      end
      S_TW_WR: begin
        wr_en = 1'b1;
        wr_data = mtg_pkg::twist_word(cur_r, rd_a_data, rd_b_data);
        cur_nxt = rd_a_data;
        if (k_r == LAST_K) begin
          index_nxt = '0;
          state_nxt = for_skip_r ? S_SK : S_NX;
        end else begin
          k_nxt = k_r + 1'b1;
          state_nxt = S_TW_RD;
        end
      end
      // next word
      S_NX: begin
        rd_a_addr = index_r[AW-1:0];
        if (index_r >= IDX_END) begin
          for_skip_nxt = 1'b0;
          state_nxt = S_TW_PRE;
        end else begin
          state_nxt = S_NX_DATA;
        end
      end
      S_NX_DATA: begin
        word_nxt = mtg_pkg::temper(rd_a_data);
        index_nxt = index_r + 1'b1;
        state_nxt = S_NX_M1;
      end
      S_NX_M1: begin
        mul_x = word_r;
        state_nxt = S_NX_M2;
      end
      S_NX_M2: begin
        mul_x = prod + 1'b1;
        state_nxt = S_NX_M3;
      end
      S_NX_M3: begin
        lcg_nxt = prod + 1'b1;
        state_nxt = S_NX_OUT;
      end
      S_NX_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rand_nxt = word_r;
          out_lcg_nxt = lcg_r;
          state_nxt = S_IDLE;
        end
      end
      // skip: jump the index by whole runs, twisting at the end of the store
      S_SK: begin
        if (rem_r == '0) begin
          state_nxt = S_IDLE;
        end else if (index_r >= IDX_END) begin
          for_skip_nxt = 1'b1;
          state_nxt = S_TW_PRE;
        end else if (rem_r <= mtg_pkg::CNT_W'(avail)) begin
          index_nxt = index_r + rem_r[IW-1:0];
          rem_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          index_nxt = IDX_END;
          rem_nxt = rem_r - mtg_pkg::CNT_W'(avail);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seeded_r <= 1'b0;
      index_r <= IDX_END;
      out_valid_r <= 1'b0;
      for_skip_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seeded_r <= seeded_nxt;
      index_r <= index_nxt;
      out_valid_r <= out_valid_nxt;
      for_skip_r <= for_skip_nxt;
    end
    k_r <= k_nxt;
    rem_r <= rem_nxt;
    p_r <= p_nxt;
    cur_r <= cur_nxt;
    word_r <= word_nxt;
    lcg_r <= lcg_nxt;
    out_rand_r <= out_rand_nxt;
    out_lcg_r <= out_lcg_nxt;
  end

  // checks
  `ASSERT_IMPL(a_index_range, 1'b1, index_r <= IDX_END)
  `ASSERT_NEXT(a_seeded_sticks, seeded_r, seeded_r)
  `ASSERT_IMPL(a_write_src, wr_en, state_r == S_SD_WR || state_r == S_TW_WR || in_acc)
  `ASSERT_IMPL(a_out_src, $rose(out_valid_r), $past(state_r == S_NX_OUT))

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TWISTER_DEPTH = 624;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [mtg_pkg::CNT_W-1:0] SKIP_MAX = '1;
  // longest quiet stretch is a full-range skip: about 1681 twists
  localparam int unsigned WATCHDOG_LIMIT = 6_500_000;
  // a seed or a twist may still be running after the last result
  localparam int unsigned DRAIN_CYCLES = 3000;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    mtg_pkg::word_t random_word;
    mtg_pkg::word_t lcg_word;
  } draw_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                in_opcode = mtg_pkg::OP_SEED;
  logic [31:0]               in_seed_value = '0;
  logic [mtg_pkg::CNT_W-1:0] in_skip_count = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [31:0]               out_random_word;
  logic [31:0]               out_lcg_word;

  // generator state as predicted from the accepted items
  mtg_pkg::word_t twister_copy [TWISTER_DEPTH];
  int unsigned    word_pos = TWISTER_DEPTH;
  bit             seeded = 1'b0;

  draw_result_t pending_draws [$];
  int unsigned  miss_count = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  stall_left = 0;
  bit           idle_on = 1'b0;

  mt19937_generator_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_seed_value   (in_seed_value),
    .in_skip_count   (in_skip_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_word (out_random_word),
    .out_lcg_word    (out_lcg_word)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // standard initialisation of the word store
  function automatic void fill_from_seed(input mtg_pkg::word_t s);
    mtg_pkg::word_t prev;
    twister_copy[0] = s;
    for (int unsigned k = 1; k < TWISTER_DEPTH; k++) begin
      prev = twister_copy[k-1];
      twister_copy[k] = mtg_pkg::INIT_MULT * (prev ^ (prev >> 30)) + mtg_pkg::word_t'(k);
    end
    word_pos = TWISTER_DEPTH;
    seeded = 1'b1;
  endfunction

  // regenerate the whole store in place
  function automatic void regenerate_store();
    mtg_pkg::word_t mix;
    mtg_pkg::word_t folded;
    for (int unsigned k = 0; k < TWISTER_DEPTH; k++) begin
      mix = {twister_copy[k][31], twister_copy[(k + 1) % TWISTER_DEPTH][30:0]};
      folded = {1'b0, mix[31:1]};
      if (mix[0]) folded = folded ^ mtg_pkg::TWIST_XOR;
      twister_copy[k] = twister_copy[(k + mtg_pkg::SHIFT_DIST) % TWISTER_DEPTH] ^ folded;
    end
    word_pos = 0;
  endfunction

  function automatic mtg_pkg::word_t next_tempered();
    mtg_pkg::word_t t;
    if (word_pos >= TWISTER_DEPTH) regenerate_store();
    t = twister_copy[word_pos];
    word_pos++;
    t = t ^ {11'b0, t[31:11]};
    t = t ^ ({t[24:0], 7'b0} & mtg_pkg::TEMPER_B);
    t = t ^ ({t[16:0], 15'b0} & mtg_pkg::TEMPER_C);
    t = t ^ {18'b0, t[31:18]};
    return t;
  endfunction

  function automatic mtg_pkg::word_t lcg_advance(input mtg_pkg::word_t x);
    return mtg_pkg::INIT_MULT * x + 32'd1;
  endfunction

  // update the predicted state for one accepted item, queue its result if any
  function automatic void predict_item(input logic [1:0] op, input mtg_pkg::word_t seed_in,
                                       input logic [mtg_pkg::CNT_W-1:0] cnt);
    draw_result_t r;
    case (op)
      mtg_pkg::OP_SEED: begin
        fill_from_seed(seed_in);
      end
      mtg_pkg::OP_NEXT: begin
        if (seeded) begin
          r.random_word = next_tempered();
          r.lcg_word = lcg_advance(lcg_advance(r.random_word));
          pending_draws = {pending_draws, r};
        end
      end
      mtg_pkg::OP_SKIP: begin
        if (seeded) begin
          for (int unsigned k = 0; k < cnt; k++) begin
            if (word_pos >= TWISTER_DEPTH) regenerate_store();
            word_pos++;
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  // present one item, hold it until accepted
  task automatic send_item(input logic [1:0] op, input mtg_pkg::word_t seed_in,
                           input logic [mtg_pkg::CNT_W-1:0] cnt);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_seed_value <= seed_in;
    in_skip_count <= cnt;
    do @(posedge clk); while (!in_ready);
    predict_item(op, seed_in, cnt);
  endtask

  function automatic logic [mtg_pkg::CNT_W-1:0] any_count();
    return mtg_pkg::CNT_W'($urandom);
  endfunction

  // next, skip and the unused opcode before any seed do nothing
  task automatic test_before_seed();
    send_item(mtg_pkg::OP_NEXT, $urandom, any_count());
    send_item(mtg_pkg::OP_SKIP, $urandom, SKIP_MAX);
    send_item(mtg_pkg::OP_SKIP, $urandom, '0);
    send_item(OP_UNUSED, $urandom, any_count());
  endtask

  // seeds at the usual default and the field extremes
  task automatic test_seed_values();
    send_item(mtg_pkg::OP_SEED, 32'd5489, any_count());
    repeat (3) send_item(mtg_pkg::OP_NEXT, $urandom, any_count());
    send_item(mtg_pkg::OP_SEED, 32'h0000_0000, any_count());
    send_item(mtg_pkg::OP_NEXT, $urandom, any_count());
    send_item(mtg_pkg::OP_SEED, 32'hFFFF_FFFF, any_count());
    send_item(mtg_pkg::OP_NEXT, $urandom, any_count());
    send_item(OP_UNUSED, $urandom, any_count());
    send_item(mtg_pkg::OP_NEXT, $urandom, any_count());
  endtask

  // skip of zero, of one, across a twist, and the largest count
  task automatic test_skip_lengths();
    send_item(mtg_pkg::OP_SKIP, $urandom, '0);
    send_item(mtg_pkg::OP_NEXT, $urandom, any_count());
    send_item(mtg_pkg::OP_SKIP, $urandom, mtg_pkg::CNT_W'(1));
    send_item(mtg_pkg::OP_NEXT, $urandom, any_count());
    send_item(mtg_pkg::OP_SKIP, $urandom, mtg_pkg::CNT_W'(622));
    send_item(mtg_pkg::OP_NEXT, $urandom, any_count());
    send_item(mtg_pkg::OP_SKIP, $urandom, SKIP_MAX);
    send_item(mtg_pkg::OP_NEXT, $urandom, any_count());
  endtask

  // mostly draws with short skips, occasional reseeds and unused opcodes
  task automatic test_random_mix(input int unsigned n_items, input bit with_idle);
    int unsigned pick;
    mtg_pkg::word_t s;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 100 == 0) idle_on = with_idle && ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        case ($urandom_range(0, 3))
          0: s = '0;
          1: s = '1;
          default: s = $urandom;
        endcase
        send_item(mtg_pkg::OP_SEED, s, any_count());
      end else if (pick < 6) begin
        send_item(OP_UNUSED, $urandom, any_count());
      end else if (pick < 26) begin
        if ($urandom_range(0, 4) == 0)
          send_item(mtg_pkg::OP_SKIP, $urandom, mtg_pkg::CNT_W'($urandom_range(0, 1300)));
        else
          send_item(mtg_pkg::OP_SKIP, $urandom, mtg_pkg::CNT_W'($urandom_range(0, 40)));
      end else begin
        send_item(mtg_pkg::OP_NEXT, $urandom, any_count());
      end
    end
  endtask

  // result side: random stalls while idling is on
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each accepted result with the oldest predicted draw
  always @(posedge clk) begin
    draw_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_draws.size() == 0) begin
        miss_count++;
        if (miss_count <= REPORT_LIMIT)
          $display("unexpected result: random_word=%h lcg_word=%h",
                   out_random_word, out_lcg_word);
      end else begin
        want = pending_draws.pop_front();
        if (out_random_word !== want.random_word || out_lcg_word !== want.lcg_word) begin
          miss_count++;
          if (miss_count <= REPORT_LIMIT)
            $display("mismatch: random_word exp %h got %h, lcg_word exp %h got %h",
                     want.random_word, out_random_word, want.lcg_word, out_lcg_word);
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_on = 1'b1;
    test_before_seed();
    test_seed_values();
    test_skip_lengths();
    test_random_mix(1300, 1'b1);
    idle_on = 1'b0;
    test_random_mix(200, 1'b0);

    // drain outstanding results, then let any trailing work finish
    in_valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (miss_count == 0 && pending_draws.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
